// File: sv/iss_pkg.sv
// shared types and constants for the integer set store
package iss_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ELEM_W = 32;
  localparam int MC_W = 5;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ELEM_W-1:0] key;
    logic [ELEM_W-1:0] last;
  } search_pkt_t;

endpackage

// File: sv/iss_cell.sv
// one store cell: holds one entry and passes the search packet to its neighbor
module iss_cell #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF,
  parameter int IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [$clog2(CAPACITY+1)-1:0]        count,
  input  logic                                 wr_en,
  input  logic [$clog2(CAPACITY)-1:0]          wr_idx,
  input  logic [iss_pkg::ELEM_W-1:0]           wr_data,
  input  iss_pkg::search_pkt_t                 pkt_in,
  input  logic [$clog2(CAPACITY)-1:0]          slot_in,
  output iss_pkg::search_pkt_t                 pkt_out,
  output logic [$clog2(CAPACITY)-1:0]          slot_out
);
  import iss_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_END = CNT_W'(IDX + 1);

  logic [ELEM_W-1:0] entry;
  logic              occupied;
  logic              is_last;
  logic              match;

  assign occupied = MY_POS < count;
  assign is_last  = MY_END == count;
  assign match    = occupied && (entry == pkt_in.key);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_SLOT)) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out.valid <= pkt_in.valid;
    end
    pkt_out.key  <= pkt_in.key;
    pkt_out.hit  <= pkt_in.hit | match;
    pkt_out.last <= is_last ? entry : pkt_in.last;
    slot_out     <= (match && !pkt_in.hit) ? MY_SLOT : slot_in;
  end

endmodule

// File: sv/integer_set_store_top.sv
// integer set store top level: control, result register and the chain of entry cells
// An item is a query, add or remove of a 32-bit value against a set of up to CAPACITY
// distinct values. Each accepted item is walked through a chain of CAPACITY cells, one
// cell per cycle; its outcome is then latched and, once the output register is free,
// committed to the count, entries and result register (default capacity 16). The input
// stalls while an item is in the chain; a finished result waits in the output register
// while the next item is searched. No clearing is needed after reset: the count starts
// at zero and entries at or above it are never compared.
module integer_set_store_top #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [iss_pkg::ELEM_W-1:0] element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [1:0]                   status,
  output logic [iss_pkg::MC_W-1:0]     member_count
);
  import iss_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  state_t            state;
  state_t            state_next;
  op_t               op_reg;
  logic [ELEM_W-1:0] key_reg;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pend_hit;
  logic [SLOT_W-1:0] pend_slot;
  logic [ELEM_W-1:0] pend_last;
  logic              accept;
  logic              commit;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  logic [ELEM_W-1:0] wr_data;
  status_t           st;
  status_t           status_reg;
  logic [CNT_W+MC_W-1:0] cnt_ext;

  search_pkt_t       chain_pkt [CAPACITY+1];
  logic [SLOT_W-1:0] chain_slot [CAPACITY+1];

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign status   = status_reg;

  assign chain_pkt[0].valid = accept;
  assign chain_pkt[0].hit   = 1'b0;
  assign chain_pkt[0].key   = $unsigned(element);
  assign chain_pkt[0].last  = '0;
  assign chain_slot[0]      = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    iss_cell #(
      .CAPACITY(CAPACITY),
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .pkt_in  (chain_pkt[i]),
      .slot_in (chain_slot[i]),
      .pkt_out (chain_pkt[i+1]),
      .slot_out(chain_slot[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    commit     = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = pend_slot;
    wr_data    = pend_last;
    count_next = count;
    st         = ST_DONE;
    case (op_reg)
      OP_ADD: begin
        if (!pend_hit) begin
          if (count == FULL_CNT) begin
            st = ST_FULL;
          end else begin
            wr_idx     = count[SLOT_W-1:0];
            wr_data    = key_reg;
            count_next = count + 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (pend_hit) begin
          count_next = count - 1'b1;
        end else begin
          st = ST_ABSENT;
        end
      end
      default: ;
    endcase
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (chain_pkt[CAPACITY].valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          wr_en      = (count_next != count);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cnt_ext = {{MC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= op_t'(operation);
      key_reg <= $unsigned(element);
    end
    if (chain_pkt[CAPACITY].valid) begin
      pend_hit  <= chain_pkt[CAPACITY].hit;
      pend_slot <= chain_slot[CAPACITY];
      pend_last <= chain_pkt[CAPACITY].last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (commit) begin
      found        <= pend_hit;
      status_reg   <= st;
      member_count <= cnt_ext[MC_W-1:0];
    end
  end

endmodule

// File: sv/iss_checker.sv
// port-level checks for the integer set store, bound to the top level
module iss_checker #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         found,
  input logic [1:0]                   status,
  input logic [iss_pkg::MC_W-1:0]     member_count
);
  import iss_pkg::*;

  localparam logic [MC_W-1:0] FULL_MC = MC_W'(CAPACITY);

  // an accepted item holds off the next one while it is searched
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after item accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(status)
      && $stable(member_count))
    else $error("stalled result changed");

  // a rejected add or a failed remove never reports a hit
  a_error_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_ABSENT) |-> !found)
    else $error("error status with found set");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> member_count == FULL_MC)
    else $error("full status with count below capacity");

  // a new result only appears after a search that kept the input stalled
  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search");

endmodule

bind integer_set_store_top iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (.*);
